// ===== src/rllt_pkg.sv =====
// Shared sizes, codes, beat types and controller/datapath interface structs.
package rllt_pkg;

  localparam int CODE_DEPTH   = 4096;
  localparam int LINE_ENTRIES = 1024;
  localparam int LINE_BITS    = 16;

  localparam int CODE_AW   = $clog2(CODE_DEPTH);
  localparam int CODE_CW   = CODE_AW + 1;
  localparam int ENT_AW    = $clog2(LINE_ENTRIES);
  localparam int ENT_CW    = ENT_AW + 1;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CODE_FULL = 2'd1;
  localparam logic [1:0] ST_LINE_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  code_byte;
    logic [15:0] line_number;
    logic [11:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] line_out;
    logic [7:0]  byte_out;
    logic [11:0] offset_out;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic search;
    logic finish;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic empty;
    logic search_done;
  } dp_stat_t;

endpackage

// ===== src/rllt_dp.sv =====
// Datapath: code and line-table memories, counters, binary search registers, result registers.
module rllt_dp (
  input  logic               clk,
  input  logic               rst,
  input  rllt_pkg::ctrl_cmd_t cmd,
  output rllt_pkg::dp_stat_t  stat,
  input  rllt_pkg::in_item_t  in_item,
  output rllt_pkg::out_item_t out_item
);

  logic [7:0]                     code_mem  [rllt_pkg::CODE_DEPTH];
  logic [rllt_pkg::CODE_AW-1:0]   offs_mem  [rllt_pkg::LINE_ENTRIES];
  logic [rllt_pkg::LINE_BITS-1:0] lines_mem [rllt_pkg::LINE_ENTRIES];

  rllt_pkg::in_item_t             in_q;
  rllt_pkg::out_item_t            res;
  rllt_pkg::out_item_t            out_q;
  logic [rllt_pkg::CODE_CW-1:0]   byte_count;
  logic [rllt_pkg::ENT_CW-1:0]    entry_count;
  logic [rllt_pkg::LINE_BITS-1:0] last_line;

  logic [7:0]                     code_rdata;
  logic [rllt_pkg::CODE_AW-1:0]   off_rdata;
  logic [rllt_pkg::LINE_BITS-1:0] line_rdata;

  logic [rllt_pkg::ENT_CW-1:0]    lo, hi, lo_next, hi_next;
  logic [rllt_pkg::ENT_AW-1:0]    mid, mid_next, best, best_next;
  logic [rllt_pkg::ENT_CW-1:0]    mid_sum;
  logic [rllt_pkg::ENT_CW-1:0]    last_idx;
  logic [rllt_pkg::ENT_AW-1:0]    init_mid;
  logic [rllt_pkg::ENT_AW-1:0]    off_raddr, line_raddr;
  logic [rllt_pkg::LINE_BITS-1:0] line_in;
  logic                           hit, brk;
  logic                           code_full, table_full, need_entry, in_code;

  assign line_in    = rllt_pkg::LINE_BITS'(in_q.line_number);
  assign code_full  = (byte_count == rllt_pkg::CODE_CW'(rllt_pkg::CODE_DEPTH));
  assign table_full = (entry_count == rllt_pkg::ENT_CW'(rllt_pkg::LINE_ENTRIES));
  assign need_entry = (entry_count == '0) || (last_line != line_in);
  assign in_code    = (32'(in_q.offset) < 32'(byte_count));
  assign last_idx   = entry_count - rllt_pkg::ENT_CW'(1);
  assign init_mid   = last_idx[rllt_pkg::ENT_AW:1];

  // One probe per cycle: compare the entry read at mid, then form the next mid.
  always_comb begin
    hit       = (32'(off_rdata) <= 32'(in_q.offset));
    lo_next   = lo;
    hi_next   = hi;
    best_next = best;
    brk       = 1'b0;
    if (hit) begin
      best_next = mid;
      lo_next   = rllt_pkg::ENT_CW'(mid) + rllt_pkg::ENT_CW'(1);
    end else if (mid == '0) begin
      brk = 1'b1;
    end else begin
      hi_next = rllt_pkg::ENT_CW'(mid) - rllt_pkg::ENT_CW'(1);
    end
    mid_sum  = lo_next + ((hi_next - lo_next) >> 1);
    mid_next = mid_sum[rllt_pkg::ENT_AW-1:0];
  end

  assign off_raddr  = cmd.decide ? init_mid : mid_next;
  assign line_raddr = cmd.search ? best_next : best;

  assign stat.is_lookup   = (in_q.kind == rllt_pkg::KIND_LOOKUP);
  assign stat.empty       = (entry_count == '0);
  assign stat.search_done = brk || (lo_next > hi_next);

  // Memories: one write port, registered reads.
  always_ff @(posedge clk) begin
    code_rdata <= code_mem[rllt_pkg::CODE_AW'(in_q.offset)];
    off_rdata  <= offs_mem[off_raddr];
    line_rdata <= lines_mem[line_raddr];
    if (cmd.decide && !stat.is_lookup && !code_full && !(need_entry && table_full)) begin
      code_mem[byte_count[rllt_pkg::CODE_AW-1:0]] <= in_q.code_byte;
      if (need_entry) begin
        offs_mem[entry_count[rllt_pkg::ENT_AW-1:0]]  <= byte_count[rllt_pkg::CODE_AW-1:0];
        lines_mem[entry_count[rllt_pkg::ENT_AW-1:0]] <= line_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      entry_count <= '0;
    end else if (cmd.decide && !stat.is_lookup && !code_full
                 && !(need_entry && table_full)) begin
      byte_count <= byte_count + rllt_pkg::CODE_CW'(1);
      if (need_entry) begin
        entry_count <= entry_count + rllt_pkg::ENT_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= in_item;
    end
    if (cmd.decide) begin
      res.line_out <= '0;
      res.byte_out <= '0;
      if (stat.is_lookup) begin
        res.offset_out <= in_q.offset;
        res.status     <= stat.empty ? rllt_pkg::ST_EMPTY : rllt_pkg::ST_OK;
        lo   <= '0;
        hi   <= last_idx;
        mid  <= init_mid;
        best <= '0;
      end else if (code_full) begin
        res.offset_out <= '0;
        res.status     <= rllt_pkg::ST_CODE_FULL;
      end else if (need_entry && table_full) begin
        res.offset_out <= '0;
        res.status     <= rllt_pkg::ST_LINE_FULL;
      end else begin
        res.offset_out <= 12'(byte_count);
        res.status     <= rllt_pkg::ST_OK;
        if (need_entry) begin
          last_line <= line_in;
        end
      end
    end
    if (cmd.search) begin
      lo   <= lo_next;
      hi   <= hi_next;
      mid  <= mid_next;
      best <= best_next;
    end
    if (cmd.finish) begin
      res.line_out <= 16'(line_rdata);
      res.byte_out <= in_code ? code_rdata : 8'd0;
    end
    if (cmd.out_load) begin
      out_q <= res;
    end
  end

  assign out_item = out_q;

endmodule

// ===== src/rllt_ctrl.sv =====
// Controller: sequences accept, decode, search, line read and result hand-off.
module rllt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rllt_pkg::dp_stat_t  stat,
  output rllt_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_LINE,
    S_RESULT
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && in_ready;
    cmd.decide   = (state == S_DECIDE);
    cmd.search   = (state == S_SEARCH);
    cmd.finish   = (state == S_LINE);
    cmd.out_load = (state == S_RESULT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (stat.is_lookup && !stat.empty) begin
            state <= S_SEARCH;
          end else begin
            state <= S_RESULT;
          end
        end
        S_SEARCH: begin
          if (stat.search_done) begin
            state <= S_LINE;
          end
        end
        S_LINE: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/run_length_line_table.sv =====
// Top level: bytecode store with run-length line table and binary-search line lookup.
//
//   channel  direction  payload               beat taken when
//   in       input      rllt_pkg::in_item_t   in_valid && in_ready
//   out      output     rllt_pkg::out_item_t  out_valid && out_ready
//
// An append, or a lookup on an empty table, passes from accept through the decide state
// to the result state; any other lookup also runs P binary search probes (at most
// log2 of the entry count plus one, 11 for 1024 entries), each one registered read of
// the start-offset memory, and then a line read before the result state.
// Reset clears only the counters and control; the memories are never cleared.
// A new beat is taken while a result waits in the output register; a stall there
// holds the next result back, and with it the accept of any further beat.
module run_length_line_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rllt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rllt_pkg::out_item_t out_item
);

  rllt_pkg::ctrl_cmd_t cmd;
  rllt_pkg::dp_stat_t  stat;

  rllt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rllt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule
